// File: hw/rtl/bq_pkg.sv
// Shared types, constants and codes for the direct form I biquad filter.
package bq_pkg;

    // Defaults for the top level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // Fixed formats: coefficients are Q4.20, the rounded sum is held in 40 bits.
    localparam int COEF_W    = 24;
    localparam int MID_W     = 40;
    localparam int MID_SPLIT = 20;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_A0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd5;

    localparam logic signed [COEF_W-1:0] UNITY_COEF = 24'sd1048576;

    // Sequencer step counter.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] MAC_LAST_STEP = 3'd4;
    localparam logic [STEP_W-1:0] SCL_LAST_STEP = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_LAST,
        ST_MID,
        ST_SCL,
        ST_SCL_LAST,
        ST_OUT
    } state_t;

    // Operand pairs that the shared multiplier can be given.
    typedef enum logic [2:0] {
        OP_B0_X,
        OP_B1_X1,
        OP_B2_X2,
        OP_A1_Y1,
        OP_A2_Y2,
        OP_INV_LO,
        OP_INV_HI
    } op_sel_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    mul_en;
        op_sel_t op;
        logic    mid_load;
        logic    out_load;
    } ctl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic out_free;
    } stat_t;

endpackage

// File: hw/rtl/bq_if.sv
// Stream interfaces for the biquad sample input and filtered output.
interface bq_in_if #(
    parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_out_if #(
    parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// File: hw/rtl/bq_mul.sv
// Shared signed multiplier with a registered product and operand tag.
module bq_mul #(
    parameter int A_W = 24,
    parameter int B_W = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  bq_pkg::op_sel_t          op,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] prod,
    output logic                     prod_valid,
    output bq_pkg::op_sel_t          prod_op
);
    localparam int P_W = A_W + B_W;

    logic signed [P_W-1:0] a_ext;
    logic signed [P_W-1:0] b_ext;
    logic signed [P_W-1:0] prod_reg;
    logic signed [P_W-1:0] prod_next;
    logic                  valid_reg;
    bq_pkg::op_sel_t       op_reg;

    // Sign-extend both operands so the product is exact.
    assign a_ext     = P_W'(a);
    assign b_ext     = P_W'(b);
    assign prod_next = a_ext * b_ext;

    // Product register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    // The tag says which operand pair the product belongs to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            op_reg    <= bq_pkg::OP_B0_X;
        end
        else
        begin
            valid_reg <= en;
            if (en)
            begin
                op_reg <= op;
            end
        end
    end

    assign prod       = prod_reg;
    assign prod_valid = valid_reg;
    assign prod_op    = op_reg;
endmodule

// File: hw/rtl/bq_ctrl.sv
// Sequencer that schedules the shared multiplier for one sample.
module bq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  bq_pkg::stat_t stat,
    output bq_pkg::ctl_t  ctl
);
    bq_pkg::state_t              state_reg;
    bq_pkg::state_t              state_next;
    logic [bq_pkg::STEP_W-1:0]   step_reg;
    logic [bq_pkg::STEP_W-1:0]   step_next;

    // State and step registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bq_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            bq_pkg::ST_IDLE:
            begin
                if (stat.in_fire)
                begin
                    state_next = bq_pkg::ST_MAC;
                    step_next  = '0;
                end
            end
            bq_pkg::ST_MAC:
            begin
                if (step_reg == bq_pkg::MAC_LAST_STEP)
                begin
                    state_next = bq_pkg::ST_MAC_LAST;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            bq_pkg::ST_MAC_LAST:
            begin
                state_next = bq_pkg::ST_MID;
            end
            bq_pkg::ST_MID:
            begin
                state_next = bq_pkg::ST_SCL;
                step_next  = '0;
            end
            bq_pkg::ST_SCL:
            begin
                if (step_reg == bq_pkg::SCL_LAST_STEP)
                begin
                    state_next = bq_pkg::ST_SCL_LAST;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            bq_pkg::ST_SCL_LAST:
            begin
                state_next = bq_pkg::ST_OUT;
            end
            bq_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = bq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bq_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Outputs: the five taps go through the multiplier first, then the
    // two halves of the rounded sum are scaled by the reciprocal of a0.
    always_comb
    begin
        ctl          = '0;
        ctl.op       = bq_pkg::OP_B0_X;
        case (state_reg)
            bq_pkg::ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
            end
            bq_pkg::ST_MAC:
            begin
                ctl.mul_en = 1'b1;
                case (step_reg)
                    3'd0:    ctl.op = bq_pkg::OP_B0_X;
                    3'd1:    ctl.op = bq_pkg::OP_B1_X1;
                    3'd2:    ctl.op = bq_pkg::OP_B2_X2;
                    3'd3:    ctl.op = bq_pkg::OP_A1_Y1;
                    default: ctl.op = bq_pkg::OP_A2_Y2;
                endcase
            end
            bq_pkg::ST_MID:
            begin
                ctl.mid_load = 1'b1;
            end
            bq_pkg::ST_SCL:
            begin
                ctl.mul_en = 1'b1;
                ctl.op     = (step_reg == '0) ? bq_pkg::OP_INV_LO : bq_pkg::OP_INV_HI;
            end
            bq_pkg::ST_OUT:
            begin
                ctl.out_load = stat.out_free;
            end
            default:
            begin
                ctl.in_ready = 1'b0;
            end
        endcase
    end
endmodule

// File: hw/rtl/biquad_direct_form_one.sv
// Top level of the direct form I biquad filter with one shared multiplier.
//
//  Channel    Kind         Word / fields
//  samples    stream sink  sample_in (signed, SAMPLE_WIDTH)
//  filtered   stream src   sample_out (signed, SAMPLE_WIDTH), clipped
//  cfg_*      write port   cfg_index selects inv_a0, a1, a2, b0, b1, b2
//
// A sample goes through steps set by the single multiplier: five tap products
// and their accumulation, the round and saturate of the sum, two partial
// products of the 1/a0 scale, then the round and saturate into the output
// register, which is written once that register is free.
// samples.ready is high only while the sequencer is idle. The output register
// holds a word until it is taken; a new sample is accepted meanwhile.
// Reset restores the coefficient defaults and clears the filter history.
module biquad_direct_form_one #(
    parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bq_pkg::COEF_W-1:0]      cfg_data,
    bq_in_if.sink                          samples,
    bq_out_if.source                       filtered
);
    localparam int CW      = bq_pkg::COEF_W;
    localparam int MW      = bq_pkg::MID_W;
    localparam int SPLIT   = bq_pkg::MID_SPLIT;
    localparam int MUL_A_W = (SAMPLE_WIDTH > SPLIT + 1) ? SAMPLE_WIDTH : SPLIT + 1;
    localparam int P_W     = MUL_A_W + CW;
    localparam int ACC_W   = P_W + 3;
    localparam int RND_W   = ((ACC_W > MW) ? ACC_W : MW) + 1;
    localparam int SCALE_W = MW + CW;

    localparam logic signed [RND_W-1:0] RND_HALF =
        RND_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] MID_MAX =
        {{(RND_W-MW+1){1'b0}}, {(MW-1){1'b1}}};
    localparam logic signed [RND_W-1:0] MID_MIN = ~MID_MAX;
    localparam logic signed [SCALE_W-1:0] SCL_HALF =
        SCALE_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [SCALE_W-1:0] OUT_MAX =
        {{(SCALE_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SCALE_W-1:0] OUT_MIN = ~OUT_MAX;

    bq_pkg::ctl_t  ctl;
    bq_pkg::stat_t stat;

    // Configuration registers.
    logic signed [CW-1:0] inv_a0_reg;
    logic signed [CW-1:0] coef_a1_reg;
    logic signed [CW-1:0] coef_a2_reg;
    logic signed [CW-1:0] coef_b0_reg;
    logic signed [CW-1:0] coef_b1_reg;
    logic signed [CW-1:0] coef_b2_reg;

    // Filter history and working registers.
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_in_one_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_in_two_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_out_one_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_out_two_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [MW-1:0]           mid_reg;
    logic                           mid_sat_reg;
    logic signed [SCALE_W-1:0]      scale_reg;
    logic signed [SCALE_W-1:0]      scale_next;

    // Output register.
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_clip_reg;

    // Multiplier connections.
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [CW-1:0]           mul_b;
    logic signed [P_W-1:0]          prod;
    logic                           prod_valid;
    bq_pkg::op_sel_t                prod_op;
    logic signed [MW-SPLIT-1:0]     mid_hi;

    // Rounding and saturation.
    logic signed [RND_W-1:0]        acc_wide;
    logic signed [RND_W-1:0]        acc_rnd;
    logic                           mid_sat;
    logic signed [MW-1:0]           mid_val;
    logic signed [SCALE_W-1:0]      scl_wide;
    logic signed [SCALE_W-1:0]      scl_rnd;
    logic                           y_sat;
    logic signed [SAMPLE_WIDTH-1:0] y_val;

    assign stat.in_fire  = samples.valid && ctl.in_ready;
    assign stat.out_free = !out_valid_reg || filtered.ready;

    bq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Operand selection for the shared multiplier.
    assign mid_hi = mid_reg[MW-1:SPLIT];

    always_comb
    begin
        case (ctl.op)
            bq_pkg::OP_B0_X:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = coef_b0_reg;
            end
            bq_pkg::OP_B1_X1:
            begin
                mul_a = MUL_A_W'(prev_in_one_reg);
                mul_b = coef_b1_reg;
            end
            bq_pkg::OP_B2_X2:
            begin
                mul_a = MUL_A_W'(prev_in_two_reg);
                mul_b = coef_b2_reg;
            end
            bq_pkg::OP_A1_Y1:
            begin
                mul_a = MUL_A_W'(prev_out_one_reg);
                mul_b = coef_a1_reg;
            end
            bq_pkg::OP_A2_Y2:
            begin
                mul_a = MUL_A_W'(prev_out_two_reg);
                mul_b = coef_a2_reg;
            end
            bq_pkg::OP_INV_LO:
            begin
                mul_a = MUL_A_W'({1'b0, mid_reg[SPLIT-1:0]});
                mul_b = inv_a0_reg;
            end
            bq_pkg::OP_INV_HI:
            begin
                mul_a = MUL_A_W'(mid_hi);
                mul_b = inv_a0_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bq_mul #(
        .A_W (MUL_A_W),
        .B_W (CW)
    ) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (ctl.mul_en),
        .op         (ctl.op),
        .a          (mul_a),
        .b          (mul_b),
        .prod       (prod),
        .prod_valid (prod_valid),
        .prod_op    (prod_op)
    );

    // Accumulate each product as it leaves the multiplier, by its tag.
    always_comb
    begin
        acc_next   = acc_reg;
        scale_next = scale_reg;
        if (stat.in_fire)
        begin
            acc_next = '0;
        end
        else if (prod_valid)
        begin
            case (prod_op)
                bq_pkg::OP_B0_X,
                bq_pkg::OP_B1_X1,
                bq_pkg::OP_B2_X2:  acc_next   = acc_reg + ACC_W'(prod);
                bq_pkg::OP_A1_Y1,
                bq_pkg::OP_A2_Y2:  acc_next   = acc_reg - ACC_W'(prod);
                bq_pkg::OP_INV_LO: scale_next = SCALE_W'(prod);
                bq_pkg::OP_INV_HI: scale_next = scale_reg + (SCALE_W'(prod) <<< SPLIT);
                default:           acc_next   = acc_reg;
            endcase
        end
    end

    // Round the tap sum and saturate it to the 40-bit intermediate.
    assign acc_wide = RND_W'(acc_reg) + RND_HALF;
    assign acc_rnd  = acc_wide >>> COEF_FRAC_BITS;
    assign mid_sat  = (acc_rnd > MID_MAX) || (acc_rnd < MID_MIN);

    always_comb
    begin
        if (acc_rnd > MID_MAX)
        begin
            mid_val = MID_MAX[MW-1:0];
        end
        else if (acc_rnd < MID_MIN)
        begin
            mid_val = MID_MIN[MW-1:0];
        end
        else
        begin
            mid_val = acc_rnd[MW-1:0];
        end
    end

    // Round the scaled value and saturate it to the sample width.
    assign scl_wide = scale_reg + SCL_HALF;
    assign scl_rnd  = scl_wide >>> COEF_FRAC_BITS;
    assign y_sat    = (scl_rnd > OUT_MAX) || (scl_rnd < OUT_MIN);

    always_comb
    begin
        if (scl_rnd > OUT_MAX)
        begin
            y_val = OUT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (scl_rnd < OUT_MIN)
        begin
            y_val = OUT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_val = scl_rnd[SAMPLE_WIDTH-1:0];
        end
    end

    // Working registers that carry data only.
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        scale_reg <= scale_next;
        if (stat.in_fire)
        begin
            x_reg <= samples.sample_in;
        end
        if (ctl.mid_load)
        begin
            mid_reg     <= mid_val;
            mid_sat_reg <= mid_sat;
        end
        if (ctl.out_load)
        begin
            out_sample_reg <= y_val;
            out_clip_reg   <= mid_sat_reg | y_sat;
        end
    end

    // Configuration, filter history and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_a0_reg       <= bq_pkg::UNITY_COEF;
            coef_a1_reg      <= '0;
            coef_a2_reg      <= '0;
            coef_b0_reg      <= bq_pkg::UNITY_COEF;
            coef_b1_reg      <= '0;
            coef_b2_reg      <= '0;
            prev_in_one_reg  <= '0;
            prev_in_two_reg  <= '0;
            prev_out_one_reg <= '0;
            prev_out_two_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bq_pkg::REG_INV_A0:  inv_a0_reg  <= cfg_data;
                    bq_pkg::REG_COEF_A1: coef_a1_reg <= cfg_data;
                    bq_pkg::REG_COEF_A2: coef_a2_reg <= cfg_data;
                    bq_pkg::REG_COEF_B0: coef_b0_reg <= cfg_data;
                    bq_pkg::REG_COEF_B1: coef_b1_reg <= cfg_data;
                    bq_pkg::REG_COEF_B2: coef_b2_reg <= cfg_data;
                    default:             inv_a0_reg  <= inv_a0_reg;
                endcase
            end
            if (ctl.out_load)
            begin
                prev_in_two_reg  <= prev_in_one_reg;
                prev_in_one_reg  <= x_reg;
                prev_out_two_reg <= prev_out_one_reg;
                prev_out_one_reg <= y_val;
                out_valid_reg    <= 1'b1;
            end
            else if (filtered.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign samples.ready       = ctl.in_ready;
    assign filtered.valid      = out_valid_reg;
    assign filtered.sample_out = out_sample_reg;
    assign filtered.clipped    = out_clip_reg;

`ifndef SYNTHESIS
    // Once a sample is taken, no other is taken until its result is built.
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("sample accepted while the previous one is in work");

    // A result is written only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || filtered.ready))
        else $error("output register overwritten before it was taken");

    // The filter history moves only when a result is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(prev_out_one_reg) |-> $past(ctl.out_load))
        else $error("output history changed without a result");
`endif
endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for the direct form I biquad, checked against a fixed-point predictor.
module testbench;

    localparam int SW   = bq_pkg::SAMPLE_WIDTH_DEF;
    localparam int FRAC = bq_pkg::COEF_FRAC_BITS_DEF;
    localparam int CW   = bq_pkg::COEF_W;
    localparam int IW   = bq_pkg::CFG_IDX_W;

    // Indexes past the last coefficient; writes to them must change nothing.
    localparam logic [IW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_B = 3'd7;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    localparam logic [CW-1:0] COEF_MAX   = 24'h7FFFFF;
    localparam logic [CW-1:0] COEF_MIN   = 24'h800000;
    localparam logic [CW-1:0] COEF_ZERO  = 24'h000000;
    localparam logic [CW-1:0] COEF_HALF  = 24'h080000;
    localparam logic [CW-1:0] COEF_MINUS = 24'hF00000;

    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC - 1);

    localparam int WORDS_PER_SET = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int END_SETTLE    = 24;

    typedef enum int {
        COEFS_TAME,
        COEFS_WILD,
        COEFS_EXTREME
    } coef_style_t;

    typedef struct packed {
        logic signed [SW-1:0] sample_out;
        logic                 clipped;
    } filtered_word_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_we;
    logic [IW-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    bq_in_if  #(.SAMPLE_WIDTH(SW)) samples_ch ();
    bq_out_if #(.SAMPLE_WIDTH(SW)) filtered_ch ();

    biquad_direct_form_one #(
        .SAMPLE_WIDTH   (SW),
        .COEF_FRAC_BITS (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .filtered  (filtered_ch)
    );

    // Predictor copy of the coefficients and the filter history.
    longint inv_c = bq_pkg::UNITY_COEF;
    longint a1_c  = 0;
    longint a2_c  = 0;
    longint b0_c  = bq_pkg::UNITY_COEF;
    longint b1_c  = 0;
    longint b2_c  = 0;
    longint x1_h  = 0;
    longint x2_h  = 0;
    longint y1_h  = 0;
    longint y2_h  = 0;

    filtered_word_t pending_outputs[$];
    int             mismatch_count = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    bit             hold_request   = 1'b0;
    bit             hold_taken     = 1'b0;
    int             hold_left      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

    // Clamp to a signed range of the given width, noting any clipping.
    function automatic longint saturate(input longint v, input int w, inout logic hit);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Filter one sample: tap sum, round, 40-bit clamp, scale by 1/a0, round, clamp.
    function automatic filtered_word_t filter_sample(input logic signed [SW-1:0] x);
        longint         xs;
        longint         acc;
        longint         mid;
        longint         scaled;
        logic           clip;
        filtered_word_t w;
        xs   = x;
        clip = 1'b0;
        acc  = b0_c * xs + b1_c * x1_h + b2_c * x2_h - a1_c * y1_h - a2_c * y2_h;
        mid    = saturate((acc + ROUND_HALF) >>> FRAC, bq_pkg::MID_W, clip);
        scaled = saturate((mid * inv_c + ROUND_HALF) >>> FRAC, SW, clip);
        // The clamped output is what feeds back.
        x2_h = x1_h;
        x1_h = xs;
        y2_h = y1_h;
        y1_h = scaled;
        w.sample_out = scaled[SW-1:0];
        w.clipped    = clip;
        return w;
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        case ($urandom_range(3))
            0: return SW'(int'($urandom_range(8191)) - 4096);
            1:
            begin
                case ($urandom_range(2))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    default: return '0;
                endcase
            end
            default: return SW'($urandom);
        endcase
    endfunction

    // Tame sets keep every coefficient within one and the scale within a quarter to one.
    function automatic logic [CW-1:0] random_coef(input coef_style_t style, input bit scale);
        case (style)
            COEFS_TAME:
            begin
                if (scale)
                    return CW'($urandom_range(1048576, 262144));
                return CW'(int'($urandom_range(2097152)) - 1048576);
            end
            COEFS_WILD: return CW'($urandom);
            default:
            begin
                case ($urandom_range(3))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return COEF_ZERO;
                    default: return bq_pkg::UNITY_COEF;
                endcase
            end
        endcase
    endfunction

    // Drive one register write; the enable stays high until the caller lowers it.
    task automatic set_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            bq_pkg::REG_INV_A0:  inv_c = $signed(data);
            bq_pkg::REG_COEF_A1: a1_c  = $signed(data);
            bq_pkg::REG_COEF_A2: a2_c  = $signed(data);
            bq_pkg::REG_COEF_B0: b0_c  = $signed(data);
            bq_pkg::REG_COEF_B1: b1_c  = $signed(data);
            bq_pkg::REG_COEF_B2: b2_c  = $signed(data);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_filter(input logic [CW-1:0] inv, input logic [CW-1:0] a1,
                                  input logic [CW-1:0] a2, input logic [CW-1:0] b0,
                                  input logic [CW-1:0] b1, input logic [CW-1:0] b2);
        set_reg(bq_pkg::REG_INV_A0, inv);
        set_reg(bq_pkg::REG_COEF_A1, a1);
        set_reg(bq_pkg::REG_COEF_A2, a2);
        set_reg(bq_pkg::REG_COEF_B0, b0);
        set_reg(bq_pkg::REG_COEF_B1, b1);
        set_reg(bq_pkg::REG_COEF_B2, b2);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one sample, with random idle cycles first, and log its expected word.
    task automatic send_sample(input logic signed [SW-1:0] x);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(negedge clk);
        end
        samples_ch.valid     <= 1'b1;
        samples_ch.sample_in <= x;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        pending_outputs.push_back(filter_sample(x));
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic wait_drained();
        samples_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int sets);
        coef_style_t style;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (sets)
        begin
            wait_drained();
            style = coef_style_t'($urandom_range(2));
            program_filter(random_coef(style, 1'b1), random_coef(style, 1'b0),
                           random_coef(style, 1'b0), random_coef(style, 1'b0),
                           random_coef(style, 1'b0), random_coef(style, 1'b0));
            repeat (WORDS_PER_SET)
                send_sample(random_sample());
        end
    endtask

    // Reset coefficients pass samples through unchanged.
    task automatic test_reset_defaults();
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SW'(1));
        send_sample(SW'(-1));
        send_sample(24'hAAAAAA);
        send_sample(24'h555555);
    endtask

    // A gain of one half puts odd samples exactly on a rounding tie.
    task automatic test_tie_rounding();
        wait_drained();
        program_filter(bq_pkg::UNITY_COEF, COEF_ZERO, COEF_ZERO, COEF_HALF, COEF_ZERO,
                       COEF_ZERO);
        send_sample(SW'(1));
        send_sample(SW'(-1));
        send_sample(SW'(3));
        send_sample(SW'(-3));
    endtask

    // Large gain clips both ways; the clipped value must come back through the a1 tap.
    task automatic test_output_clipping();
        wait_drained();
        program_filter(bq_pkg::UNITY_COEF, COEF_MINUS, COEF_ZERO, COEF_MAX, COEF_ZERO,
                       COEF_ZERO);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('0);
    endtask

    // Every register at its top and bottom value, with spare indexes written in between.
    task automatic test_extreme_coefs();
        wait_drained();
        program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        wait_drained();
        set_reg(REG_SPARE_A, CW'($urandom));
        set_reg(REG_SPARE_B, CW'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
        send_sample(SW'(1));
        wait_drained();
        program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
    endtask

    // The receiver holds off while samples keep coming, so the block backs up.
    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        program_filter(random_coef(COEFS_TAME, 1'b1), random_coef(COEFS_TAME, 1'b0),
                       random_coef(COEFS_TAME, 1'b0), random_coef(COEFS_TAME, 1'b0),
                       random_coef(COEFS_TAME, 1'b0), random_coef(COEFS_TAME, 1'b0));
        hold_request = 1'b1;
        repeat (30)
            send_sample(random_sample());
        hold_request = 1'b0;
        wait_drained();
    endtask

    task automatic test_no_idling();
        run_random_phase(0, 0, 4);
    endtask

    task automatic test_sender_gaps();
        run_random_phase(85, 0, 4);
    endtask

    task automatic test_receiver_stalls();
        run_random_phase(0, 85, 4);
    endtask

    task automatic test_both_idle();
        run_random_phase(38, 38, 4);
    endtask

    // Receiver ready: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        else if (!hold_request)
        begin
            hold_taken = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            filtered_ch.ready <= 1'b0;
        end
        else
            filtered_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin : check_filtered
        filtered_word_t want;
        if (rst_n && filtered_ch.valid && filtered_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected word: sample_out %0d, clipped %0b",
                       filtered_ch.sample_out, filtered_ch.clipped);
                mismatch_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (filtered_ch.sample_out !== want.sample_out)
                begin
                    $error("sample_out mismatch: expected %0d, got %0d",
                           want.sample_out, filtered_ch.sample_out);
                    mismatch_count++;
                end
                if (filtered_ch.clipped !== want.clipped)
                begin
                    $error("clipped mismatch: expected %0b, got %0b",
                           want.clipped, filtered_ch.clipped);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = bq_pkg::REG_INV_A0;
        cfg_data             = '0;
        samples_ch.valid     = 1'b0;
        samples_ch.sample_in = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_tie_rounding();
        test_output_clipping();
        test_extreme_coefs();
        test_back_pressure();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
